// File: rtl/fcbb_pkg.sv
// Package for the frame change bounding box block.
// Holds field widths, port widths, register indexes and parameter defaults.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package fcbb_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam int PIX_W      = 32;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 8;

    localparam int S_TDATA_W = 2 * PIX_W;
    localparam int M_FIELD_W = 2 * POS_W + 2 * SIZE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

endpackage

`default_nettype wire

// File: rtl/frame_change_bounding_box.sv
// A pixel pair is first held in the input register and updates the box as it leaves it; the
// result of a frame is registered onto m_tvalid as its last pixel leaves the input register.
// Throughput: one pixel pair per cycle, set by the input register feeding a
// single compare-and-update stage; stalls only while a result waits on m_tready.
// Reset (aresetn low at a clock edge): counters, box and both valid flags clear,
// frame_width and frame_height return to 1.
//
// Top level of the frame change bounding box; depends on fcbb_pkg.
`default_nettype none

module frame_change_bounding_box #(
    parameter int MAX_DIM = fcbb_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Fields from bit 0: prev_pixel, cur_pixel.
    input  wire logic [fcbb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: rect_x, rect_y, rect_width, rect_height, zero padding.
    output logic [fcbb_pkg::M_TDATA_W-1:0]          m_tdata,
    // Fields from bit 0: unchanged.
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [fcbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fcbb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > fcbb_pkg::SIZE_W) ? CNT_W + 1 : fcbb_pkg::SIZE_W;
    localparam int EXT_W = (CNT_W > fcbb_pkg::POS_W) ? CNT_W : fcbb_pkg::POS_W;
    localparam int PW    = fcbb_pkg::PIX_W;

    logic [fcbb_pkg::CFG_DATA_W-1:0] frame_width_reg;
    logic [fcbb_pkg::CFG_DATA_W-1:0] frame_height_reg;

    logic             diff_reg;
    logic             in_valid_reg;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             any_reg, any_next;
    logic [CNT_W-1:0] min_x_reg, min_x_next;
    logic [CNT_W-1:0] min_y_reg, min_y_next;
    logic [CNT_W-1:0] max_x_reg, max_x_next;
    logic [CNT_W-1:0] max_y_reg, max_y_next;

    logic [fcbb_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tvalid_reg;

    logic [CMP_W-1:0] width_ext, height_ext, eff_w, eff_h;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             row_end, frame_end, advance;

    logic             any_upd;
    logic [CNT_W-1:0] min_x_upd, min_y_upd, max_x_upd, max_y_upd;
    logic [EXT_W-1:0] min_x_ext, min_y_ext;
    logic [CMP_W-1:0] span_x, span_y;
    logic [fcbb_pkg::M_FIELD_W-1:0] result_fields;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= fcbb_pkg::CFG_DATA_W'(1);
            frame_height_reg <= fcbb_pkg::CFG_DATA_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == fcbb_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wdata;
            end
            if (cfg_index == fcbb_pkg::REG_FRAME_HEIGHT) begin
                frame_height_reg <= cfg_wdata;
            end
        end
    end

    // Effective frame size: zero counts as one, anything above MAX_DIM is clamped.
    always_comb begin
        width_ext  = CMP_W'(frame_width_reg);
        height_ext = CMP_W'(frame_height_reg);
        if (width_ext == '0) begin
            eff_w = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_DIM)) begin
            eff_w = CMP_W'(MAX_DIM);
        end else begin
            eff_w = width_ext;
        end
        if (height_ext == '0) begin
            eff_h = CMP_W'(1);
        end else if (height_ext > CMP_W'(MAX_DIM)) begin
            eff_h = CMP_W'(MAX_DIM);
        end else begin
            eff_h = height_ext;
        end
    end

    assign col_inc   = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(row_reg) + CMP_W'(1);
    assign row_end   = !(col_inc < eff_w);
    assign frame_end = row_end && !(row_inc < eff_h);

    // A pixel that closes no frame never waits on the result register.
    assign advance  = in_valid_reg && (!frame_end || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            diff_reg <= s_tdata[PW-1:0] != s_tdata[2*PW-1:PW];
        end
    end

    always_comb begin
        any_upd   = any_reg;
        min_x_upd = min_x_reg;
        min_y_upd = min_y_reg;
        max_x_upd = max_x_reg;
        max_y_upd = max_y_reg;
        if (diff_reg) begin
            any_upd = 1'b1;
            if (!any_reg) begin
                min_x_upd = col_reg;
                max_x_upd = col_reg;
                min_y_upd = row_reg;
                max_y_upd = row_reg;
            end else begin
                if (col_reg < min_x_reg) min_x_upd = col_reg;
                if (col_reg > max_x_reg) max_x_upd = col_reg;
                if (row_reg < min_y_reg) min_y_upd = row_reg;
                if (row_reg > max_y_reg) max_y_upd = row_reg;
            end
        end
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        any_next   = any_reg;
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (advance) begin
            if (frame_end) begin
                col_next   = '0;
                row_next   = '0;
                any_next   = 1'b0;
                min_x_next = '0;
                min_y_next = '0;
                max_x_next = '0;
                max_y_next = '0;
            end else begin
                col_next   = row_end ? '0 : col_inc[CNT_W-1:0];
                row_next   = row_end ? row_inc[CNT_W-1:0] : row_reg;
                any_next   = any_upd;
                min_x_next = min_x_upd;
                min_y_next = min_y_upd;
                max_x_next = max_x_upd;
                max_y_next = max_y_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            any_reg   <= 1'b0;
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            any_reg   <= any_next;
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    assign min_x_ext = EXT_W'(min_x_upd);
    assign min_y_ext = EXT_W'(min_y_upd);
    assign span_x    = CMP_W'(max_x_upd) - CMP_W'(min_x_upd) + CMP_W'(1);
    assign span_y    = CMP_W'(max_y_upd) - CMP_W'(min_y_upd) + CMP_W'(1);

    always_comb begin
        if (any_upd) begin
            result_fields = {span_y[fcbb_pkg::SIZE_W-1:0], span_x[fcbb_pkg::SIZE_W-1:0],
                             min_y_ext[fcbb_pkg::POS_W-1:0], min_x_ext[fcbb_pkg::POS_W-1:0]};
        end else begin
            result_fields = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && frame_end) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_end) begin
            m_tdata_reg <= fcbb_pkg::M_TDATA_W'(result_fields);
            m_tuser_reg <= !any_upd;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// File: rtl/fcbb_port_checker.sv
// Port-level checker for the frame change bounding box, bound to the top level.
// Depends on fcbb_pkg for port widths.
`default_nettype none

module fcbb_port_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [fcbb_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    // A result that is not taken holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An unchanged frame reports an empty rectangle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("unchanged frame with nonzero rectangle");

    // A fresh result is preceded by an input transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding input transaction");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind frame_change_bounding_box fcbb_port_checker u_fcbb_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
